@@ design/csr_sparse_matrix_store_matvec_core_assert.svh @@
// Assertion macros shared by the sparse matrix store checker.
// No dependencies; include by bare file name.
`ifndef CSR_SPARSE_MATRIX_STORE_MATVEC_CORE_ASSERT_SVH
`define CSR_SPARSE_MATRIX_STORE_MATVEC_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define CSM_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define CSM_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/csm_pkg.sv @@
// Shared types and constants for the sparse matrix store core.
// No dependencies.
package csm_pkg;

    localparam int CFG_W            = 7;
    localparam int FRAC_BITS        = 16;
    localparam int DIGIT_W          = 16;
    localparam int DEF_MAX_ROWS     = 64;
    localparam int DEF_MAX_COLS     = 64;
    localparam int DEF_MAX_NONZEROS = 256;
    localparam int DEF_VALUE_BITS   = 32;

    // configuration register indexes
    localparam logic CFG_ROWS = 1'b0;
    localparam logic CFG_COLS = 1'b1;

    typedef enum logic [1:0] {
        CMD_GET   = 2'd0,
        CMD_SET   = 2'd1,
        CMD_LOADX = 2'd2,
        CMD_MULT  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_RANGE = 2'd1,
        STAT_FULL  = 2'd2
    } t_status;

    typedef enum logic [4:0] {
        S_IDLE,
        S_PTR_A,
        S_PTR_B,
        S_PTR_C,
        S_SCAN,
        S_SCAN_CHK,
        S_DECIDE,
        S_SHD_RD,
        S_SHD_WR,
        S_SHU_RD,
        S_SHU_WR,
        S_BUMP_RD,
        S_BUMP_WR,
        S_MAC_RD,
        S_MAC_X,
        S_MAC_GO,
        S_MAC_WAIT,
        S_SAT,
        S_RESP
    } t_state;

    typedef enum logic [2:0] {
        M_IDLE,
        M_DIGIT,
        M_NEG,
        M_ROUND,
        M_DONE
    } t_mul_state;

endpackage

@@ design/csm_ram.sv @@
// Generic single-write, single-read synchronous RAM, registered read data.
// No dependencies.
module csm_ram #(
    parameter int DW    = 32,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered read data
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/csm_mul.sv @@
// Multicycle signed fixed-point multiplier: 16-bit digits of |b| per cycle,
// then sign, then round-to-nearest shift by the fraction bits. Uses csm_pkg.
module csm_mul #(
    parameter int VALUE_BITS = csm_pkg::DEF_VALUE_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic signed [VALUE_BITS-1:0] i_a,
    input  logic signed [VALUE_BITS-1:0] i_b,
    output logic                         o_done,
    output logic signed [2*VALUE_BITS-1:0] o_prod
);
    import csm_pkg::*;

    localparam int ND  = (VALUE_BITS + DIGIT_W - 1) / DIGIT_W;
    localparam int BW  = ND * DIGIT_W;
    localparam int PW  = BW + VALUE_BITS;
    localparam int KW  = (ND > 1) ? $clog2(ND) : 1;
    localparam int QW  = 2 * VALUE_BITS;

    t_mul_state r_state, n_state;
    logic [VALUE_BITS-1:0] r_ma, n_ma;
    logic [BW-1:0]         r_mb, n_mb;
    logic                  r_neg, n_neg;
    logic [PW-1:0]         r_p, n_p;
    logic [KW-1:0]         r_k, n_k;
    logic signed [QW-1:0]  r_q, n_q;
    logic [VALUE_BITS+DIGIT_W-1:0] part;
    logic signed [PW-1:0]  rnd;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_ma  <= n_ma;
        r_mb  <= n_mb;
        r_neg <= n_neg;
        r_p   <= n_p;
        r_k   <= n_k;
        r_q   <= n_q;
    end

    // next state and datapath
    always_comb begin
        n_state = r_state;
        n_ma    = r_ma;
        n_mb    = r_mb;
        n_neg   = r_neg;
        n_p     = r_p;
        n_k     = r_k;
        n_q     = r_q;
        part    = r_ma * r_mb[BW-1 -: DIGIT_W];
        rnd     = $signed(r_p) + $signed(PW'(1) << (FRAC_BITS - 1));
        unique case (r_state)
            M_IDLE: begin
                if (i_start) begin
                    n_ma    = i_a[VALUE_BITS-1] ? VALUE_BITS'(-i_a) : VALUE_BITS'(i_a);
                    n_mb    = BW'(i_b[VALUE_BITS-1] ? VALUE_BITS'(-i_b) : VALUE_BITS'(i_b));
                    n_neg   = i_a[VALUE_BITS-1] ^ i_b[VALUE_BITS-1];
                    n_p     = '0;
                    n_k     = '0;
                    n_state = M_DIGIT;
                end
            end
            // most significant digit first: p = p * 2^16 + |a| * digit
            M_DIGIT: begin
                n_p  = (r_p << DIGIT_W) + PW'(part);
                n_mb = r_mb << DIGIT_W;
                n_k  = r_k + KW'(1);
                if (32'(r_k) == ND - 1) begin
                    n_state = M_NEG;
                end
            end
            M_NEG: begin
                n_p     = r_neg ? -r_p : r_p;
                n_state = M_ROUND;
            end
            M_ROUND: begin
                n_q     = QW'(rnd >>> FRAC_BITS);
                n_state = M_DONE;
            end
            M_DONE: begin
                n_state = M_IDLE;
            end
            default: n_state = M_IDLE;
        endcase
    end

    assign o_done = (r_state == M_DONE);
    assign o_prod = r_q;

endmodule

@@ design/csr_sparse_matrix_store_matvec_core.sv @@
// One command at a time. After accept, load_x and range errors go straight to the result
// beat; get/set reads both row pointers, then scans the row to the first entry at or above
// the column. Insert/remove then shift each later entry and bump each row pointer above
// the row. multiply_row sums entry times x, saturated; next accept in the cycle after the beat.
// Synchronous active-low reset clears the pointer table, x vector and count at once.
// Each result is a one-cycle strobe beat; the receiver cannot stall it.
module csr_sparse_matrix_store_matvec_core #(
    parameter int MAX_ROWS     = csm_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS     = csm_pkg::DEF_MAX_COLS,
    parameter int MAX_NONZEROS = csm_pkg::DEF_MAX_NONZEROS,
    parameter int VALUE_BITS   = csm_pkg::DEF_VALUE_BITS,
    parameter int RW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
    parameter int CW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
    parameter int NZ_W = $clog2(MAX_NONZEROS + 1)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    output logic                         o_busy,
    input  logic [1:0]                   i_command,
    input  logic [RW-1:0]                i_row_index,
    input  logic [CW-1:0]                i_col_index,
    input  logic signed [VALUE_BITS-1:0] i_data_value,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_index,
    input  logic [csm_pkg::CFG_W-1:0]    i_cfg_data,
    output logic                         o_strobe,
    output logic signed [VALUE_BITS-1:0] o_result_value,
    output logic [1:0]                   o_status,
    output logic                         o_entry_found,
    output logic [NZ_W-1:0]              o_nonzero_total
);
    import csm_pkg::*;

    localparam int J_W    = $clog2(MAX_ROWS + 2);
    localparam int EA_W   = (MAX_NONZEROS > 1) ? $clog2(MAX_NONZEROS) : 1;
    localparam int ED_W   = CW + VALUE_BITS;
    localparam int ACC_W  = 2 * VALUE_BITS + NZ_W;
    localparam int TB_W   = (VALUE_BITS > NZ_W) ? VALUE_BITS : NZ_W;
    localparam int TB_D   = MAX_ROWS + 1 + MAX_COLS;
    localparam int TA_W   = $clog2(TB_D);
    localparam int X_BASE = MAX_ROWS + 1;
    localparam logic signed [ACC_W-1:0] SAT_MAX = (ACC_W'(1) <<< (VALUE_BITS - 1)) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] SAT_MIN = -(ACC_W'(1) <<< (VALUE_BITS - 1));

    // configuration
    logic [CFG_W-1:0] r_rows, r_cols;
    logic [31:0]      rows_eff, cols_eff;

    // control and command registers
    t_state                  r_state, n_state;
    logic [1:0]              r_cmd, n_cmd;
    logic [RW-1:0]           r_row, n_row;
    logic [CW-1:0]           r_col, n_col;
    logic [VALUE_BITS-1:0]   r_val, n_val;
    logic [NZ_W-1:0]         r_nnz, n_nnz;
    logic [NZ_W-1:0]         r_start, n_start;
    logic [NZ_W-1:0]         r_end, n_end;
    logic [NZ_W-1:0]         r_pos, n_pos;
    logic [NZ_W-1:0]         r_i, n_i;
    logic [J_W-1:0]          r_j, n_j;
    logic                    r_up, n_up;
    logic [VALUE_BITS-1:0]   r_ev, n_ev;
    logic signed [ACC_W-1:0] r_acc, n_acc;
    logic [VALUE_BITS-1:0]   r_res, n_res;
    logic [1:0]              r_stat, n_stat;
    logic                    r_found, n_found;

    // valid bits for the table entries that reset to zero
    logic [TB_D-1:0] r_tb_vld;
    logic            r_tb_rvld;

    // table memory: row pointers at 0..MAX_ROWS, x vector above them
    logic              tb_we;
    logic [TA_W-1:0]   tb_waddr, tb_raddr;
    logic [TB_W-1:0]   tb_wdata, tb_rraw, tb_rd;
    logic [NZ_W-1:0]   ptr_rd;
    logic [VALUE_BITS-1:0] x_rd;

    // entry memory: column and value per stored nonzero
    logic              ent_we;
    logic [EA_W-1:0]   ent_waddr, ent_raddr;
    logic [ED_W-1:0]   ent_wdata, ent_rd;
    logic [CW-1:0]     ent_col;
    logic [VALUE_BITS-1:0] ent_val;

    // multiplier
    logic                           mul_start, mul_done;
    logic signed [2*VALUE_BITS-1:0] mul_prod;

    logic accept;
    logic row_ok, col_ok;

    csm_ram #(.DW(TB_W), .DEPTH(TB_D), .AW(TA_W)) u_tbl_ram (
        .i_clk(i_clk), .i_we(tb_we), .i_waddr(tb_waddr), .i_wdata(tb_wdata),
        .i_raddr(tb_raddr), .o_rdata(tb_rraw)
    );

    csm_ram #(.DW(ED_W), .DEPTH(MAX_NONZEROS), .AW(EA_W)) u_ent_ram (
        .i_clk(i_clk), .i_we(ent_we), .i_waddr(ent_waddr), .i_wdata(ent_wdata),
        .i_raddr(ent_raddr), .o_rdata(ent_rd)
    );

    csm_mul #(.VALUE_BITS(VALUE_BITS)) u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(mul_start),
        .i_a($signed(r_ev)), .i_b($signed(x_rd)), .o_done(mul_done), .o_prod(mul_prod)
    );

    assign tb_rd   = r_tb_rvld ? tb_rraw : '0;
    assign ptr_rd  = tb_rd[NZ_W-1:0];
    assign x_rd    = tb_rd[VALUE_BITS-1:0];
    assign ent_col = ent_rd[ED_W-1:VALUE_BITS];
    assign ent_val = ent_rd[VALUE_BITS-1:0];

    // effective shape, clamped to 1..MAX
    assign rows_eff = (r_rows == '0) ? 32'd1 :
                      (32'(r_rows) > MAX_ROWS) ? 32'(MAX_ROWS) : 32'(r_rows);
    assign cols_eff = (r_cols == '0) ? 32'd1 :
                      (32'(r_cols) > MAX_COLS) ? 32'(MAX_COLS) : 32'(r_cols);
    assign row_ok   = 32'(i_row_index) < rows_eff;
    assign col_ok   = 32'(i_col_index) < cols_eff;

    assign accept = i_start && (r_state == S_IDLE);

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= CFG_W'(64);
            r_cols <= CFG_W'(64);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ROWS: r_rows <= i_cfg_data;
                CFG_COLS: r_cols <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // state and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_nnz    <= '0;
            r_tb_vld <= '0;
        end else begin
            r_state <= n_state;
            r_nnz   <= n_nnz;
            if (tb_we) r_tb_vld[tb_waddr] <= 1'b1;
        end
    end

    // read-side valid flag follows the RAM latency
    always_ff @(posedge i_clk) begin
        r_tb_rvld <= r_tb_vld[tb_raddr];
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_row   <= n_row;
        r_col   <= n_col;
        r_val   <= n_val;
        r_start <= n_start;
        r_end   <= n_end;
        r_pos   <= n_pos;
        r_i     <= n_i;
        r_j     <= n_j;
        r_up    <= n_up;
        r_ev    <= n_ev;
        r_acc   <= n_acc;
        r_res   <= n_res;
        r_stat  <= n_stat;
        r_found <= n_found;
    end

    // sequencer: next state, memory control and datapath
    always_comb begin
        n_state = r_state;
        n_cmd = r_cmd;   n_row = r_row;     n_col = r_col;   n_val = r_val;
        n_nnz = r_nnz;   n_start = r_start; n_end = r_end;   n_pos = r_pos;
        n_i = r_i;       n_j = r_j;         n_up = r_up;     n_ev = r_ev;
        n_acc = r_acc;   n_res = r_res;     n_stat = r_stat; n_found = r_found;
        tb_we = 1'b0; tb_waddr = TA_W'(r_j); tb_wdata = '0;
        tb_raddr = TA_W'(r_row);
        ent_we = 1'b0; ent_waddr = r_pos[EA_W-1:0]; ent_wdata = {r_col, r_val};
        ent_raddr = r_pos[EA_W-1:0];
        mul_start = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_cmd = i_command; n_row = i_row_index;
                    n_col = i_col_index; n_val = i_data_value;
                    n_res = '0; n_stat = STAT_OK; n_found = 1'b0; n_acc = '0;
                    if (i_command == CMD_LOADX) begin
                        if (col_ok) begin
                            tb_we    = 1'b1;
                            tb_waddr = TA_W'(X_BASE) + TA_W'(i_col_index);
                            tb_wdata = TB_W'($unsigned(i_data_value));
                        end else begin
                            n_stat = STAT_RANGE;
                        end
                        n_state = S_RESP;
                    end else if (!row_ok || (i_command != CMD_MULT && !col_ok)) begin
                        n_stat  = STAT_RANGE;
                        n_state = S_RESP;
                    end else begin
                        n_state = S_PTR_A;
                    end
                end
            end
            S_PTR_A: begin
                tb_raddr = TA_W'(r_row);
                n_state  = S_PTR_B;
            end
            S_PTR_B: begin
                tb_raddr = TA_W'(r_row) + TA_W'(1);
                n_start  = ptr_rd;
                n_state  = S_PTR_C;
            end
            S_PTR_C: begin
                n_end   = ptr_rd;
                n_pos   = r_start;
                n_i     = r_start;
                n_state = (r_cmd == CMD_MULT) ? S_MAC_RD : S_SCAN;
            end
            // find first entry whose column is not below the target
            S_SCAN: begin
                ent_raddr = r_pos[EA_W-1:0];
                n_state   = (r_pos == r_end) ? S_DECIDE : S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                if (ent_col >= r_col) begin
                    n_found = (ent_col == r_col);
                    n_ev    = ent_val;
                    n_state = S_DECIDE;
                end else begin
                    n_pos   = r_pos + NZ_W'(1);
                    n_state = S_SCAN;
                end
            end
            S_DECIDE: begin
                n_state = S_RESP;
                if (r_cmd == CMD_GET) begin
                    n_res = r_found ? r_ev : '0;
                end else if (r_found) begin
                    if (r_val == '0) begin
                        n_i     = r_pos + NZ_W'(1);
                        n_state = S_SHD_RD;
                    end else begin
                        ent_we = 1'b1;
                        n_res  = r_val;
                    end
                end else if (r_val != '0) begin
                    if (32'(r_nnz) >= MAX_NONZEROS) begin
                        n_stat = STAT_FULL;
                    end else begin
                        n_i     = r_nnz;
                        n_state = S_SHU_RD;
                    end
                end
            end
            // removal: move later entries down one place
            S_SHD_RD: begin
                ent_raddr = r_i[EA_W-1:0];
                if (r_i >= r_nnz) begin
                    n_up    = 1'b0;
                    n_j     = J_W'(r_row) + J_W'(1);
                    n_state = S_BUMP_RD;
                end else begin
                    n_state = S_SHD_WR;
                end
            end
            S_SHD_WR: begin
                ent_we    = 1'b1;
                ent_waddr = EA_W'(r_i - NZ_W'(1));
                ent_wdata = ent_rd;
                n_i       = r_i + NZ_W'(1);
                n_state   = S_SHD_RD;
            end
            // insertion: move later entries up one place, then write the gap
            S_SHU_RD: begin
                ent_raddr = EA_W'(r_i - NZ_W'(1));
                if (r_i == r_pos) begin
                    ent_we  = 1'b1;
                    n_res   = r_val;
                    n_up    = 1'b1;
                    n_j     = J_W'(r_row) + J_W'(1);
                    n_state = S_BUMP_RD;
                end else begin
                    n_state = S_SHU_WR;
                end
            end
            S_SHU_WR: begin
                ent_we    = 1'b1;
                ent_waddr = r_i[EA_W-1:0];
                ent_wdata = ent_rd;
                n_i       = r_i - NZ_W'(1);
                n_state   = S_SHU_RD;
            end
            // adjust every row pointer above the row
            S_BUMP_RD: begin
                tb_raddr = TA_W'(r_j);
                if (32'(r_j) > MAX_ROWS) begin
                    n_nnz   = r_up ? r_nnz + NZ_W'(1) : r_nnz - NZ_W'(1);
                    n_state = S_RESP;
                end else begin
                    n_state = S_BUMP_WR;
                end
            end
            S_BUMP_WR: begin
                tb_we    = 1'b1;
                tb_waddr = TA_W'(r_j);
                tb_wdata = TB_W'(r_up ? ptr_rd + NZ_W'(1) : ptr_rd - NZ_W'(1));
                n_j      = r_j + J_W'(1);
                n_state  = S_BUMP_RD;
            end
            // row dot product
            S_MAC_RD: begin
                ent_raddr = r_i[EA_W-1:0];
                n_state   = (r_i == r_end) ? S_SAT : S_MAC_X;
            end
            S_MAC_X: begin
                tb_raddr = TA_W'(X_BASE) + TA_W'(ent_col);
                n_ev     = ent_val;
                n_state  = S_MAC_GO;
            end
            S_MAC_GO: begin
                mul_start = 1'b1;
                n_state   = S_MAC_WAIT;
            end
            S_MAC_WAIT: begin
                if (mul_done) begin
                    n_acc   = r_acc + ACC_W'(mul_prod);
                    n_i     = r_i + NZ_W'(1);
                    n_state = S_MAC_RD;
                end
            end
            S_SAT: begin
                if (r_acc > SAT_MAX)      n_res = SAT_MAX[VALUE_BITS-1:0];
                else if (r_acc < SAT_MIN) n_res = SAT_MIN[VALUE_BITS-1:0];
                else                      n_res = r_acc[VALUE_BITS-1:0];
                n_state = S_RESP;
            end
            S_RESP: begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // result beat
    assign o_busy          = (r_state != S_IDLE);
    assign o_strobe        = (r_state == S_RESP);
    assign o_result_value  = $signed(r_res);
    assign o_status        = r_stat;
    assign o_entry_found   = r_found;
    assign o_nonzero_total = r_nnz;

endmodule

@@ design/csm_checker.sv @@
// Port-level checker for the sparse matrix store core, bound to the top level.
// Depends on csm_pkg and csr_sparse_matrix_store_matvec_core_assert.svh.
`include "csr_sparse_matrix_store_matvec_core_assert.svh"

module csm_checker #(
    parameter int NZ_W       = 9,
    parameter int VALUE_BITS = csm_pkg::DEF_VALUE_BITS
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_start,
    input logic                         o_busy,
    input logic                         o_strobe,
    input logic signed [VALUE_BITS-1:0] o_result_value,
    input logic [1:0]                   o_status,
    input logic                         o_entry_found,
    input logic [NZ_W-1:0]              o_nonzero_total
);
    import csm_pkg::*;

    // an accepted command makes the block busy
    `CSM_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, i_start && !o_busy, o_busy, "not busy after accept")

    // a beat closes a command and is a single cycle
    `CSM_ASSERT_IMP(a_strobe_busy, i_clk, i_rst_n, o_strobe, o_busy, "strobe while idle")
    `CSM_ASSERT_NXT(a_strobe_once, i_clk, i_rst_n, o_strobe, !o_strobe, "strobe held two cycles")

    // failed commands return zero and no hit
    `CSM_ASSERT_IMP(a_err_zero, i_clk, i_rst_n, o_strobe && (o_status != STAT_OK),
        (o_result_value == '0) && !o_entry_found, "error beat carries data")

    // count changes only inside a command
    `CSM_ASSERT_IMP(a_nnz_idle, i_clk, i_rst_n, !o_busy && !$past(o_busy),
        $stable(o_nonzero_total), "count moved while idle")

endmodule

bind csr_sparse_matrix_store_matvec_core csm_checker #(
    .NZ_W(NZ_W), .VALUE_BITS(VALUE_BITS)
) u_csm_checker (.*);

@@ sim/testbench.sv @@
// Self-checking testbench for csr_sparse_matrix_store_matvec_core.
// Drives random get/set/load_x/multiply_row commands and checks every result beat.
// Depends on csm_pkg and the core RTL.
`timescale 1ns / 1ps

module testbench;
    import csm_pkg::*;

    localparam int NROW = 64;
    localparam int NCOL = 64;
    localparam int NNZ  = 256;

    typedef struct packed {
        logic signed [31:0] value;
        t_status            status;
        logic               found;
        logic [8:0]         total;
    } t_answer;

    // Behavioral copy of the store plus the queue of pending answers
    class matrix_scoreboard;
        logic [8:0]         row_ptr[NROW+1];
        logic [5:0]         col_of[NNZ];
        logic signed [31:0] val_of[NNZ];
        logic signed [31:0] xv[NCOL];
        int                 nnz;
        int                 rows_used;
        int                 cols_used;
        t_answer            pending[$];
        int                 errors;

        function new();
            foreach (row_ptr[i]) row_ptr[i] = '0;
            foreach (xv[i]) xv[i] = '0;
            nnz = 0; rows_used = 64; cols_used = 64; errors = 0;
        endfunction

        function int clamp(int v);
            if (v < 1) return 1;
            return v > 64 ? 64 : v;
        endfunction

        function void write_cfg(logic idx, logic [6:0] data);
            if (idx == CFG_ROWS) rows_used = int'(data);
            else cols_used = int'(data);
        endfunction

        function void shift_ptrs(int row, int delta);
            for (int j = row + 1; j <= NROW; j++) row_ptr[j] = 9'(int'(row_ptr[j]) + delta);
        endfunction

        // Work out one command's answer and update the model state
        function void note_command(t_cmd cmd, logic [5:0] row, logic [5:0] col,
                                   logic signed [31:0] data);
            t_answer a;
            int nr, nc, s, e, pos;
            logic signed [79:0] acc, prod;
            nr = clamp(rows_used);
            nc = clamp(cols_used);
            a = '{value: '0, status: STAT_OK, found: 1'b0, total: '0};
            if (cmd == CMD_LOADX) begin
                if (col >= nc) a.status = STAT_RANGE;
                else xv[col] = data;
            end else if (row >= nr || (cmd != CMD_MULT && col >= nc)) begin
                a.status = STAT_RANGE;
            end else begin
                s = int'(row_ptr[row]);
                e = int'(row_ptr[row+1]);
                if (cmd == CMD_MULT) begin
                    acc = '0;
                    for (int i = s; i < e; i++) begin
                        prod = 80'(val_of[i]) * 80'(xv[col_of[i]]);
                        acc += (prod + 80'sd32768) >>> 16;
                    end
                    if (acc > 80'sd2147483647) a.value = 32'h7fffffff;
                    else if (acc < -80'sd2147483648) a.value = 32'h80000000;
                    else a.value = acc[31:0];
                end else begin
                    pos = e;
                    for (int i = s; i < e; i++)
                        if (col_of[i] == col) begin
                            pos = i; a.found = 1'b1; break;
                        end
                    if (cmd == CMD_GET) begin
                        if (a.found) a.value = val_of[pos];
                    end else if (a.found) begin
                        if (data == 0) begin
                            for (int i = pos + 1; i < nnz; i++) begin
                                col_of[i-1] = col_of[i];
                                val_of[i-1] = val_of[i];
                            end
                            shift_ptrs(row, -1);
                            nnz--;
                        end else begin
                            val_of[pos] = data;
                            a.value = data;
                        end
                    end else if (data != 0) begin
                        if (nnz >= NNZ) a.status = STAT_FULL;
                        else begin
                            pos = s;
                            while (pos < e && col_of[pos] < col) pos++;
                            for (int i = nnz; i > pos; i--) begin
                                col_of[i] = col_of[i-1];
                                val_of[i] = val_of[i-1];
                            end
                            col_of[pos] = col;
                            val_of[pos] = data;
                            shift_ptrs(row, 1);
                            nnz++;
                            a.value = data;
                        end
                    end
                end
            end
            a.total = 9'(nnz);
            pending.insert(pending.size(), a);
        endfunction

        function void check_beat(t_answer got);
            t_answer exp_a;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result beat: %p", got);
                return;
            end
            exp_a = pending.pop_front();
            if (got !== exp_a) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: exp val=%h st=%0d f=%0d nz=%0d  got val=%h st=%0d f=%0d nz=%0d",
                             exp_a.value, exp_a.status, exp_a.found, exp_a.total,
                             got.value, got.status, got.found, got.total);
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         command;
    logic [5:0]         row_index;
    logic [5:0]         col_index;
    logic signed [31:0] data_value;
    logic               cfg_we;
    logic               cfg_index;
    logic [6:0]         cfg_data;
    logic               strobe;
    logic signed [31:0] result_value;
    logic [1:0]         status;
    logic               entry_found;
    logic [8:0]         nonzero_total;

    matrix_scoreboard sb;
    int  cycles = 0;
    bit  quiet_stretch;

    csr_sparse_matrix_store_matvec_core dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_start(start), .o_busy(busy),
        .i_command(command), .i_row_index(row_index), .i_col_index(col_index),
        .i_data_value(data_value), .i_cfg_we(cfg_we), .i_cfg_index(cfg_index),
        .i_cfg_data(cfg_data), .o_strobe(strobe), .o_result_value(result_value),
        .o_status(status), .o_entry_found(entry_found), .o_nonzero_total(nonzero_total)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Result monitor and run limit
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (rst_n && strobe)
            sb.check_beat('{value: result_value, status: t_status'(status),
                            found: entry_found, total: nonzero_total});
        if (cycles > 3000000) begin
            $display("** csr_sparse_matrix_store_matvec_core: FAILED **");
            $finish;
        end
    end

    // One command beat; raises start, keeps it up while busy and drops it once the block is idle
    task automatic issue(t_cmd cmd, logic [5:0] row, logic [5:0] col,
                         logic signed [31:0] data);
        while (!quiet_stretch && $urandom_range(99) < 7) @(posedge clk);
        start      <= 1'b1;
        command    <= cmd;
        row_index  <= row;
        col_index  <= col;
        data_value <= data;
        @(posedge clk);
        while (busy) @(posedge clk);
        sb.note_command(cmd, row, col, data);
        start <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [6:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.write_cfg(idx, data);
        @(posedge clk);
    endtask

    function automatic logic signed [31:0] rand_value();
        case ($urandom_range(5))
            0: return 32'sd0;
            1: return 32'h7fffffff;
            2: return 32'h80000000;
            3: return $urandom_range(1, 5) << 16;
            default: return $urandom;
        endcase
    endfunction

    task automatic random_phase(int count, int row_span, int col_span);
        int k;
        t_cmd c;
        for (k = 0; k < count; k++) begin
            quiet_stretch = (k >= count / 3 && k < count / 2);
            c = t_cmd'($urandom_range(3));
            if ($urandom_range(9) < 4) c = CMD_SET;
            issue(c, $urandom_range(9) == 0 ? 6'($urandom) : 6'($urandom_range(row_span)),
                  $urandom_range(9) == 0 ? 6'($urandom) : 6'($urandom_range(col_span)),
                  rand_value());
        end
        quiet_stretch = 1'b0;
    endtask

    initial begin
        sb = new();
        quiet_stretch = 1'b0;
        rst_n = 1'b0; start = 1'b0; command = CMD_GET; row_index = '0; col_index = '0;
        data_value = '0; cfg_we = 1'b0; cfg_index = CFG_ROWS; cfg_data = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty reads, extremes, insert ordering, update, removal
        issue(CMD_GET, 6'd0, 6'd0, 32'sd0);
        issue(CMD_MULT, 6'd63, 6'd0, 32'sd0);
        issue(CMD_LOADX, 6'd0, 6'd63, 32'h7fffffff);
        issue(CMD_LOADX, 6'd0, 6'd0, 32'h80000000);
        issue(CMD_LOADX, 6'd0, 6'd5, 32'sh00018000);
        issue(CMD_SET, 6'd63, 6'd63, 32'h7fffffff);
        issue(CMD_SET, 6'd63, 6'd0, 32'h80000000);
        issue(CMD_SET, 6'd63, 6'd5, 32'sh00010000);
        issue(CMD_MULT, 6'd63, 6'd0, 32'sd0);
        issue(CMD_SET, 6'd0, 6'd5, -32'sd3);
        issue(CMD_GET, 6'd63, 6'd5, 32'sd0);
        issue(CMD_SET, 6'd63, 6'd5, 32'sh00020000);
        issue(CMD_SET, 6'd63, 6'd0, 32'sd0);
        issue(CMD_SET, 6'd10, 6'd10, 32'sd0);
        issue(CMD_GET, 6'd63, 6'd0, 32'sd0);
        issue(CMD_MULT, 6'd0, 6'd0, 32'sd0);
        drain();

        // Shrunk shape, then out-of-range registers that saturate
        write_reg(CFG_ROWS, 7'd4);
        write_reg(CFG_COLS, 7'd3);
        issue(CMD_GET, 6'd63, 6'd5, 32'sd0);
        issue(CMD_LOADX, 6'd0, 6'd3, 32'sd7);
        issue(CMD_SET, 6'd3, 6'd2, 32'sd9);
        issue(CMD_MULT, 6'd3, 6'd60, 32'sd0);
        random_phase(35, 5, 4);
        drain();
        write_reg(CFG_ROWS, 7'd0);
        write_reg(CFG_COLS, 7'd127);
        random_phase(20, 2, 63);
        drain();
        write_reg(CFG_ROWS, 7'd1);
        write_reg(CFG_COLS, 7'd1);
        random_phase(10, 1, 1);
        drain();

        // Full shape: distinct positions fill the store past capacity, then mixed traffic
        write_reg(CFG_ROWS, 7'd64);
        write_reg(CFG_COLS, 7'd64);
        for (int k = 0; k < 290; k++) begin
            quiet_stretch = (k >= 100 && k < 170);
            issue(CMD_SET, 6'(k), 6'(k / 64), $urandom_range(1, 32'hffff));
        end
        quiet_stretch = 1'b0;
        drain();
        random_phase(15, 63, 63);
        drain();
        random_phase(10, 7, 63);
        drain();

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("** csr_sparse_matrix_store_matvec_core: PASSED **");
        else
            $display("** csr_sparse_matrix_store_matvec_core: FAILED **");
        $finish;
    end
endmodule
